/* rtl/uartx_pkg.sv */
// Shared constants for the UART transceiver with receive echo.
// Holds default parameter values, the reset bit period and the echo control codes.
// No dependencies.
`default_nettype none

package uartx_pkg;

    localparam int BYTE_W                   = 8;
    localparam int PERIOD_W                 = 16;
    localparam int DATA_BITS_DEFAULT        = 8;
    localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1666;

    localparam logic [BYTE_W-1:0] CODE_ECHO_ON  = 8'h05;
    localparam logic [BYTE_W-1:0] CODE_ECHO_OFF = 8'h06;

endpackage

`default_nettype wire

/* rtl/uart_transceiver_with_echo_top.sv */
// UART 8N1 transceiver with receive echo: timing, transmitter, receiver and echo queue.
// Depends on uartx_pkg for default parameters, the reset bit period and control codes.
// Each accepted input transaction is one tick of the baud timing base. A transaction is
// held in an input register, processed in one pass, and its result leaves from a result
// register, and one transaction is accepted in every cycle while the result side keeps
// up. Bit timing counts transactions, not clock cycles. bit_period resets to 1666 and
// takes its low bits as the tick counter width allows; a period of zero behaves as one.
`default_nettype none

module uart_transceiver_with_echo_top #(
    parameter int DATA_BITS        = uartx_pkg::DATA_BITS_DEFAULT,
    parameter int TICK_COUNT_WIDTH = uartx_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_we,
    input  wire logic [uartx_pkg::PERIOD_W-1:0]  cfg_wdata,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            rx_level,
    input  wire logic                            send_valid,
    input  wire logic [uartx_pkg::BYTE_W-1:0]    send_byte,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 tx_level,
    output logic                                 tx_busy,
    output logic                                 send_accepted,
    output logic                                 rx_valid,
    output logic [uartx_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                 echo_on
);

    import uartx_pkg::*;

    localparam int PW  = (TICK_COUNT_WIDTH < PERIOD_W) ? TICK_COUNT_WIDTH : PERIOD_W;
    localparam int RCW = PW + 1;
    localparam int IW  = $clog2(DATA_BITS + 3);

    localparam logic [IW-1:0] IDX_LAST = IW'(DATA_BITS);
    localparam logic [IW-1:0] IDX_STOP = IW'(DATA_BITS + 1);

    logic [PW-1:0]        bit_period_reg;

    logic                 in_full_reg;
    logic                 in_rx_level_reg;
    logic                 in_send_valid_reg;
    logic [BYTE_W-1:0]    in_send_byte_reg;

    logic                 out_full_reg;
    logic                 tx_level_reg;
    logic                 tx_busy_reg;
    logic                 send_accepted_reg;
    logic                 rx_valid_reg;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic                 echo_on_reg;

    logic                 echo_flag_reg,    echo_flag_next;
    logic [DATA_BITS-1:0] tx_shift_reg,     tx_shift_next;
    logic [IW-1:0]        tx_bit_index_reg, tx_bit_index_next;
    logic [PW-1:0]        tx_tick_count_reg, tx_tick_count_next;
    logic                 tx_active_reg,    tx_active_next;
    logic                 pend_valid_reg,   pend_valid_next;
    logic [DATA_BITS-1:0] pend_data_reg,    pend_data_next;
    logic [DATA_BITS-1:0] rx_shift_reg,     rx_shift_next;
    logic [IW-1:0]        rx_bit_index_reg, rx_bit_index_next;
    logic [RCW-1:0]       rx_tick_count_reg, rx_tick_count_next;

    logic                 tx_level_next;
    logic                 accepted_next;
    logic                 rx_valid_next;
    logic [BYTE_W-1:0]    rx_byte_next;

    logic                 advance;
    logic [PW-1:0]        period_eff;
    logic [PW+1:0]        period_triple;
    logic [RCW-1:0]       rx_delay;

    assign advance   = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign out_valid = out_full_reg;

    assign tx_level      = tx_level_reg;
    assign tx_busy       = tx_busy_reg;
    assign send_accepted = send_accepted_reg;
    assign rx_valid      = rx_valid_reg;
    assign rx_byte       = rx_byte_reg;
    assign echo_on       = echo_on_reg;

    assign period_eff    = (bit_period_reg == '0) ? PW'(1) : bit_period_reg;
    assign period_triple = {2'b00, period_eff} + {1'b0, period_eff, 1'b0};
    assign rx_delay      = period_triple[PW+1:1];

    always_comb
    begin
        logic [PW-1:0]        tx_cnt_inc;
        logic [IW-1:0]        tx_idx_inc;
        logic [IW-1:0]        tx_sel;
        logic [DATA_BITS-1:0] tx_shifted;
        logic [DATA_BITS-1:0] rx_assembled;

        echo_flag_next     = echo_flag_reg;
        tx_shift_next      = tx_shift_reg;
        tx_bit_index_next  = tx_bit_index_reg;
        tx_tick_count_next = tx_tick_count_reg;
        tx_active_next     = tx_active_reg;
        pend_valid_next    = pend_valid_reg;
        pend_data_next     = pend_data_reg;
        rx_shift_next      = rx_shift_reg;
        rx_bit_index_next  = rx_bit_index_reg;
        rx_tick_count_next = rx_tick_count_reg;
        tx_level_next      = 1'b1;
        accepted_next      = 1'b0;
        rx_valid_next      = 1'b0;
        rx_byte_next       = '0;

        rx_assembled = {in_rx_level_reg, rx_shift_reg[DATA_BITS-1:1]};

        if (rx_bit_index_reg == '0)
        begin
            if (!in_rx_level_reg)
            begin
                rx_tick_count_next = rx_delay;
                rx_shift_next      = '0;
                rx_bit_index_next  = IW'(1);
            end
        end
        else if (rx_tick_count_reg > RCW'(1))
        begin
            rx_tick_count_next = rx_tick_count_reg - RCW'(1);
        end
        else if (rx_bit_index_reg > IDX_LAST)
        begin
            rx_tick_count_next = '0;
            rx_bit_index_next  = '0;
        end
        else
        begin
            rx_shift_next      = rx_assembled;
            rx_tick_count_next = RCW'(period_eff);
            rx_bit_index_next  = rx_bit_index_reg + IW'(1);
            if (rx_bit_index_reg == IDX_LAST)
            begin
                rx_valid_next = 1'b1;
                rx_byte_next  = BYTE_W'(rx_assembled);
                if (echo_flag_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_data_next  = rx_assembled;
                end
                if (BYTE_W'(rx_assembled) == CODE_ECHO_ON)
                begin
                    echo_flag_next = 1'b1;
                end
                if (BYTE_W'(rx_assembled) == CODE_ECHO_OFF)
                begin
                    echo_flag_next = 1'b0;
                end
            end
        end

        if (!tx_active_reg)
        begin
            if (pend_valid_next)
            begin
                tx_shift_next      = pend_data_next;
                pend_valid_next    = 1'b0;
                pend_data_next     = '0;
                tx_active_next     = 1'b1;
                tx_bit_index_next  = '0;
                tx_tick_count_next = '0;
            end
            else if (in_send_valid_reg)
            begin
                tx_shift_next      = in_send_byte_reg[DATA_BITS-1:0];
                tx_active_next     = 1'b1;
                accepted_next      = 1'b1;
                tx_bit_index_next  = '0;
                tx_tick_count_next = '0;
            end
        end

        tx_sel     = tx_bit_index_next - IW'(1);
        tx_shifted = tx_shift_next >> tx_sel;
        tx_cnt_inc = tx_tick_count_next + PW'(1);
        tx_idx_inc = tx_bit_index_next + IW'(1);

        if (tx_active_next)
        begin
            if (tx_bit_index_next == '0)
            begin
                tx_level_next = 1'b0;
            end
            else if (tx_bit_index_next <= IDX_LAST)
            begin
                tx_level_next = tx_shifted[0];
            end
            else
            begin
                tx_level_next = 1'b1;
            end

            if (tx_cnt_inc >= period_eff)
            begin
                tx_tick_count_next = '0;
                if (tx_idx_inc > IDX_STOP)
                begin
                    tx_bit_index_next = '0;
                    tx_active_next    = 1'b0;
                end
                else
                begin
                    tx_bit_index_next = tx_idx_inc;
                end
            end
            else
            begin
                tx_tick_count_next = tx_cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= PERIOD_RESET[PW-1:0];
        end
        else if (cfg_we)
        begin
            bit_period_reg <= cfg_wdata[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_rx_level_reg   <= rx_level;
            in_send_valid_reg <= send_valid;
            in_send_byte_reg  <= send_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg      <= 1'b0;
            echo_flag_reg     <= 1'b0;
            tx_shift_reg      <= '0;
            tx_bit_index_reg  <= '0;
            tx_tick_count_reg <= '0;
            tx_active_reg     <= 1'b0;
            pend_valid_reg    <= 1'b0;
            pend_data_reg     <= '0;
            rx_shift_reg      <= '0;
            rx_bit_index_reg  <= '0;
            rx_tick_count_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_full_reg      <= 1'b1;
                echo_flag_reg     <= echo_flag_next;
                tx_shift_reg      <= tx_shift_next;
                tx_bit_index_reg  <= tx_bit_index_next;
                tx_tick_count_reg <= tx_tick_count_next;
                tx_active_reg     <= tx_active_next;
                pend_valid_reg    <= pend_valid_next;
                pend_data_reg     <= pend_data_next;
                rx_shift_reg      <= rx_shift_next;
                rx_bit_index_reg  <= rx_bit_index_next;
                rx_tick_count_reg <= rx_tick_count_next;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_level_reg      <= tx_level_next;
            tx_busy_reg       <= tx_active_next || pend_valid_next;
            send_accepted_reg <= accepted_next;
            rx_valid_reg      <= rx_valid_next;
            rx_byte_reg       <= rx_byte_next;
            echo_on_reg       <= echo_flag_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_bit_index_reg <= IDX_STOP)
        else $error("receiver bit index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(tx_active_reg) |-> $past(tx_bit_index_reg) == IDX_STOP)
        else $error("transmitter stopped before the stop bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> in_full_reg && $stable(in_send_byte_reg)
            && $stable(in_send_valid_reg) && $stable(in_rx_level_reg))
        else $error("stalled input transaction lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !tx_active_reg && pend_valid_reg) |=> !send_accepted_reg)
        else $error("host request taken while an echo was pending");
`endif

endmodule

`default_nettype wire
